>>> hw/rtl/canonical_huffman_decoder_core_assert.svh
// assertion macros for the canonical huffman decoder
`ifndef CANONICAL_HUFFMAN_DECODER_CORE_ASSERT_SVH
`define CANONICAL_HUFFMAN_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked on clk with reset masked
`define CHD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chd check failed");

// next-cycle implication
`define CHD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chd check failed");

`endif

>>> hw/rtl/chd_pkg.sv
// shared types and constants of the canonical huffman decoder
package chd_pkg;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_DEPTH_DEF = 512;

  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int CNT_W   = 9;
  localparam int IDX_W   = 9;
  localparam int SYM_W   = 9;
  localparam int SUM_W   = IDX_W + 1;
  localparam int DCMP_W  = 11;

  localparam logic [SYM_W-1:0] SYM_END    = 9'd256;
  localparam logic [SYM_W-1:0] SYM_ESCAPE = 9'd257;
  localparam logic [3:0]       RAW_BITS   = 4'd8;

  typedef enum logic [1:0] {
    KIND_LEN     = 2'd0,
    KIND_SYM     = 2'd1,
    KIND_DATA    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CODE_W-1:0] first_code;
    logic [CNT_W-1:0]  code_count;
    logic [IDX_W-1:0]  symbol_base;
  } len_entry_t;

  typedef struct packed {
    logic             hit;
    logic [SUM_W-1:0] addr;
    logic             addr_ok;
  } match_t;

  typedef struct packed {
    logic [7:0] data;
    logic       end_flag;
    logic       err;
  } result_t;

endpackage

>>> hw/rtl/chd_if.sv
// valid/ready channel interfaces of the canonical huffman decoder
interface chd_in_if;
  logic                          valid;
  logic                          ready;
  chd_pkg::kind_t                kind;
  logic [chd_pkg::LEN_W-1:0]     code_length;
  logic [chd_pkg::CODE_W-1:0]    first_code;
  logic [chd_pkg::CNT_W-1:0]     code_count;
  logic [chd_pkg::IDX_W-1:0]     symbol_base;
  logic [chd_pkg::IDX_W-1:0]     symbol_index;
  logic [chd_pkg::SYM_W-1:0]     symbol_value;
  logic [7:0]                    data_byte;

  modport source (
    output valid, kind, code_length, first_code, code_count, symbol_base,
           symbol_index, symbol_value, data_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, code_length, first_code, code_count, symbol_base,
           symbol_index, symbol_value, data_byte,
    output ready
  );
endinterface

interface chd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_seen;
  logic       code_error;
  logic       last;

  modport source (output valid, out_byte, end_seen, code_error, last, input ready);
  modport sink   (input valid, out_byte, end_seen, code_error, last, output ready);
endinterface

>>> hw/rtl/chd_ram.sv
// generic single-write, single-read ram with registered read data
module chd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/chd_match.sv
// range check of the current code against one length entry, symbol address
module chd_match #(
  parameter int SYMBOL_DEPTH = chd_pkg::SYMBOL_DEPTH_DEF
) (
  input  logic [chd_pkg::CODE_W-1:0] code,
  input  chd_pkg::len_entry_t        entry,
  input  logic                       entry_valid,
  output chd_pkg::match_t            match
);

  logic [chd_pkg::CODE_W:0]     diff;
  logic [chd_pkg::CNT_W-1:0]    cnt_eff;
  logic [chd_pkg::SUM_W-1:0]    sum;

  // borrow out of the subtract means code is below the first code
  assign diff    = {1'b0, code} - {1'b0, entry.first_code};
  assign cnt_eff = entry_valid ? entry.code_count : '0;
  assign sum     = {1'b0, entry.symbol_base} + {1'b0, diff[chd_pkg::IDX_W-1:0]};

  always_comb begin
    match.hit     = (cnt_eff != '0) && !diff[chd_pkg::CODE_W] &&
                    (diff[chd_pkg::CODE_W-1:0] <
                     {{(chd_pkg::CODE_W-chd_pkg::CNT_W){1'b0}}, cnt_eff});
    match.addr    = sum;
    match.addr_ok = {1'b0, sum} < chd_pkg::DCMP_W'(SYMBOL_DEPTH);
  end

endmodule

>>> hw/rtl/canonical_huffman_decoder_core.sv
// canonical huffman decoder: top level with bit sequencer and table memories
//
// Items arrive on in_ch. Kind 0 writes one per-length entry (first code,
// count, symbol base), kind 1 writes one symbol store word, kind 3 restarts
// the stream and kind 2 carries a compressed byte, read lsb first. Load and
// restart items give no result. A data byte is worked bit by bit: every
// code bit costs a length table read and a range check, a match adds a
// symbol store read and a result hand-off (no hand-off for an escape
// symbol, no symbol store read for a code error), and raw escape bits are
// taken one at a time, the last one of an escape with a hand-off. Once the
// end symbol has stopped decoding, bytes go straight to the final flush.
// in_ch is not ready while a byte is worked. Results leave on out_ch
// through an output register, one beat per decoded symbol, end marker or
// code error, with last on the final beat of the byte. When out_ch stalls
// the sequencer waits at its next hand-off. Reset clears the decode state
// and the per-length valid bits; table contents stay undefined until
// loaded.
`include "canonical_huffman_decoder_core_assert.svh"
module canonical_huffman_decoder_core #(
  parameter int MAX_CODE_LEN = chd_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_DEPTH = chd_pkg::SYMBOL_DEPTH_DEF
) (
  input logic           clk,
  input logic           rst_n,
  chd_in_if.sink        in_ch,
  chd_out_if.source     out_ch
);

  localparam int LEN_AW = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
  localparam int SYM_AW = (SYMBOL_DEPTH > 1) ? $clog2(SYMBOL_DEPTH) : 1;
  localparam int LEN_EW = $bits(chd_pkg::len_entry_t);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BIT   = 6'b000010,
    S_LOOK  = 6'b000100,
    S_SYM   = 6'b001000,
    S_EMIT  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [7:0]                    byte_r, byte_nxt;
  logic [3:0]                    bit_idx_r, bit_idx_nxt;
  logic [chd_pkg::CODE_W-1:0]    code_r, code_nxt;
  logic [chd_pkg::LEN_W-1:0]     code_bits_r, code_bits_nxt;
  logic                          esc_active_r, esc_active_nxt;
  logic [3:0]                    esc_bits_r, esc_bits_nxt;
  logic [7:0]                    esc_val_r, esc_val_nxt;
  logic                          stopped_r, stopped_nxt;
  logic [MAX_CODE_LEN-1:0]       len_valid_r, len_valid_nxt;
  logic                          sym_ok_r, sym_ok_nxt;
  chd_pkg::result_t              res_r, res_nxt;
  chd_pkg::result_t              pend_r, pend_nxt;
  logic                          pend_v_r, pend_v_nxt;
  logic                          out_valid_r, out_valid_nxt;
  chd_pkg::result_t              out_res_r, out_res_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          accept;
  logic                          out_free;
  logic                          cur_bit;
  logic [7:0]                    esc_shift;
  logic [chd_pkg::SYM_W-1:0]     sym_val;
  logic [chd_pkg::IDX_W:0]       sym_widx;

  logic                          len_we;
  logic [LEN_AW-1:0]             len_waddr;
  logic [LEN_AW-1:0]             len_raddr;
  logic [LEN_AW-1:0]             look_idx;
  chd_pkg::len_entry_t           len_wentry;
  logic [LEN_EW-1:0]             len_rdata;
  chd_pkg::len_entry_t           len_rd;
  logic                          sym_we;
  logic [SYM_AW-1:0]             sym_waddr;
  logic [chd_pkg::SYM_W-1:0]     sym_rdata;
  chd_pkg::match_t               match;

  // per-length table: first code, count and symbol base in one word
  chd_ram #(
    .WIDTH (LEN_EW),
    .DEPTH (MAX_CODE_LEN)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wentry),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  chd_ram #(
    .WIDTH (chd_pkg::SYM_W),
    .DEPTH (SYMBOL_DEPTH)
  ) u_sym_ram (
    .clk   (clk),
    .we    (sym_we),
    .waddr (sym_waddr),
    .wdata (in_ch.symbol_value),
    .raddr (match.addr[SYM_AW-1:0]),
    .rdata (sym_rdata)
  );

  assign len_rd = len_rdata;

  chd_match #(
    .SYMBOL_DEPTH (SYMBOL_DEPTH)
  ) u_match (
    .code        (code_r),
    .entry       (len_rd),
    .entry_valid (len_valid_r[look_idx]),
    .match       (match)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // table row for length n sits at address n-1
  assign len_raddr = LEN_AW'(code_bits_r);
  assign look_idx  = LEN_AW'(code_bits_r - chd_pkg::LEN_W'(1));
  assign len_waddr = LEN_AW'(in_ch.code_length - chd_pkg::LEN_W'(1));
  assign len_we    = accept && (in_ch.kind == chd_pkg::KIND_LEN) &&
                     (in_ch.code_length != '0) &&
                     (in_ch.code_length <= chd_pkg::LEN_W'(MAX_CODE_LEN));
  assign sym_widx  = {1'b0, in_ch.symbol_index};
  assign sym_waddr = SYM_AW'(sym_widx);
  assign sym_we    = accept && (in_ch.kind == chd_pkg::KIND_SYM) &&
                     ({1'b0, sym_widx} < chd_pkg::DCMP_W'(SYMBOL_DEPTH));

  always_comb begin
    len_wentry.first_code  = in_ch.first_code;
    len_wentry.code_count  = in_ch.code_count;
    len_wentry.symbol_base = in_ch.symbol_base;
  end

  assign cur_bit   = byte_r[bit_idx_r[2:0]];
  assign esc_shift = {esc_val_r[6:0], cur_bit};
  assign sym_val   = sym_ok_r ? sym_rdata : '0;

  always_comb begin
    state_nxt      = state_r;
    byte_nxt       = byte_r;
    bit_idx_nxt    = bit_idx_r;
    code_nxt       = code_r;
    code_bits_nxt  = code_bits_r;
    esc_active_nxt = esc_active_r;
    esc_bits_nxt   = esc_bits_r;
    esc_val_nxt    = esc_val_r;
    stopped_nxt    = stopped_r;
    len_valid_nxt  = len_valid_r;
    sym_ok_nxt     = sym_ok_r;
    res_nxt        = res_r;
    pend_nxt       = pend_r;
    pend_v_nxt     = pend_v_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_res_nxt    = out_res_r;
    out_last_nxt   = out_last_r;

    if (len_we) begin
      len_valid_nxt[len_waddr] = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.kind)
            chd_pkg::KIND_DATA: begin
              byte_nxt    = in_ch.data_byte;
              bit_idx_nxt = '0;
              state_nxt   = S_BIT;
            end
            chd_pkg::KIND_RESTART: begin
              code_nxt       = '0;
              code_bits_nxt  = '0;
              esc_active_nxt = 1'b0;
              esc_bits_nxt   = '0;
              esc_val_nxt    = '0;
              stopped_nxt    = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_BIT: begin
        if (bit_idx_r[3] || stopped_r) begin
          state_nxt = S_FLUSH;
        end else if (esc_active_r) begin
          if (esc_bits_r == chd_pkg::RAW_BITS - 4'd1) begin
            res_nxt        = '{data: esc_shift, end_flag: 1'b0, err: 1'b0};
            esc_active_nxt = 1'b0;
            esc_bits_nxt   = '0;
            esc_val_nxt    = '0;
            state_nxt      = S_EMIT;
          end else begin
            esc_val_nxt  = esc_shift;
            esc_bits_nxt = esc_bits_r + 4'd1;
            bit_idx_nxt  = bit_idx_r + 4'd1;
          end
        end else begin
          code_nxt      = {code_r[chd_pkg::CODE_W-2:0], cur_bit};
          code_bits_nxt = code_bits_r + chd_pkg::LEN_W'(1);
          state_nxt     = S_LOOK;
        end
      end
      S_LOOK: begin
        if (match.hit) begin
          code_nxt      = '0;
          code_bits_nxt = '0;
          sym_ok_nxt    = match.addr_ok;
          state_nxt     = S_SYM;
        end else if (code_bits_r >= chd_pkg::LEN_W'(MAX_CODE_LEN)) begin
          res_nxt       = '{data: 8'd0, end_flag: 1'b0, err: 1'b1};
          code_nxt      = '0;
          code_bits_nxt = '0;
          state_nxt     = S_EMIT;
        end else begin
          bit_idx_nxt = bit_idx_r + 4'd1;
          state_nxt   = S_BIT;
        end
      end
      S_SYM: begin
        if (sym_val == chd_pkg::SYM_ESCAPE) begin
          esc_active_nxt = 1'b1;
          esc_bits_nxt   = '0;
          esc_val_nxt    = '0;
          bit_idx_nxt    = bit_idx_r + 4'd1;
          state_nxt      = S_BIT;
        end else if (sym_val == chd_pkg::SYM_END) begin
          res_nxt     = '{data: 8'd0, end_flag: 1'b1, err: 1'b0};
          stopped_nxt = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          res_nxt   = '{data: sym_val[7:0], end_flag: 1'b0, err: 1'b0};
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // one result is held back so that last can be set on the final beat
        if (!pend_v_r) begin
          pend_nxt    = res_r;
          pend_v_nxt  = 1'b1;
          bit_idx_nxt = bit_idx_r + 4'd1;
          state_nxt   = S_BIT;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = pend_r;
          out_last_nxt  = 1'b0;
          pend_nxt      = res_r;
          bit_idx_nxt   = bit_idx_r + 4'd1;
          state_nxt     = S_BIT;
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = pend_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      code_r       <= '0;
      code_bits_r  <= '0;
      esc_active_r <= 1'b0;
      esc_bits_r   <= '0;
      esc_val_r    <= '0;
      stopped_r    <= 1'b0;
      len_valid_r  <= '0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      code_r       <= code_nxt;
      code_bits_r  <= code_bits_nxt;
      esc_active_r <= esc_active_nxt;
      esc_bits_r   <= esc_bits_nxt;
      esc_val_r    <= esc_val_nxt;
      stopped_r    <= stopped_nxt;
      len_valid_r  <= len_valid_nxt;
      pend_v_r     <= pend_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    byte_r     <= byte_nxt;
    bit_idx_r  <= bit_idx_nxt;
    sym_ok_r   <= sym_ok_nxt;
    res_r      <= res_nxt;
    pend_r     <= pend_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_res_r.data;
  assign out_ch.end_seen   = out_res_r.end_flag;
  assign out_ch.code_error = out_res_r.err;
  assign out_ch.last       = out_last_r;

  `CHD_ASSERT_NOW(a_ready_no_pend, in_ch.ready, !pend_v_r)
  `CHD_ASSERT_NOW(a_esc_clear, !esc_active_r, esc_bits_r == 4'd0)
  `CHD_ASSERT_NOW(a_code_len, state_r == S_BIT, code_bits_r < chd_pkg::LEN_W'(MAX_CODE_LEN))
  `CHD_ASSERT_NEXT(a_data_busy, accept && (in_ch.kind == chd_pkg::KIND_DATA), !in_ch.ready)

endmodule
